FILE: rtl/rpab_pkg.sv
// ----------------------------------------------------------------------------
// rpab_pkg
// shared widths and constants of the rms pixel accumulation buffer
// ----------------------------------------------------------------------------
package rpab_pkg;
  localparam int CH_W  = 16;
  localparam int SQ_W  = 2 * CH_W;
  localparam int CRD_W = 13;
  localparam int REG_W = 9;

  localparam logic [1:0] OP_ACC  = 2'd0;
  localparam logic [1:0] OP_PEAK = 2'd1;
  localparam logic [1:0] OP_READ = 2'd2;

  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;
endpackage

FILE: rtl/rpab_mul.sv
// ----------------------------------------------------------------------------
// rpab_mul
// bit-serial shift-add multiplier, one multiplier bit per cycle
// ----------------------------------------------------------------------------
module rpab_mul
  import rpab_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [CH_W-1:0] a,
  input  logic [CH_W-1:0] b,
  output logic            done,
  output logic [SQ_W-1:0] prod
);
  logic [SQ_W:0]           p;
  logic [CH_W-1:0]         a_r;
  logic [$clog2(CH_W)-1:0] cnt;
  logic                    busy;
  logic [CH_W:0]           hi;

  always_comb begin
    hi = p[0] ? ({1'b0, p[SQ_W-1:CH_W]} + {1'b0, a_r}) : {1'b0, p[SQ_W-1:CH_W]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == $clog2(CH_W)'(CH_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      p   <= {{(CH_W + 1){1'b0}}, b};
      a_r <= a;
    end else if (busy) begin
      p <= {1'b0, hi, p[CH_W-1:1]};
    end
  end

  assign prod = p[SQ_W-1:0];
endmodule

FILE: rtl/rpab_div.sv
// ----------------------------------------------------------------------------
// rpab_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module rpab_div
  import rpab_pkg::*;
#(
  parameter int DW = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [SQ_W-1:0] dividend,
  input  logic [DW-1:0]   divisor,
  output logic            done,
  output logic [SQ_W-1:0] quot,
  output logic            rem_nz
);
  logic [SQ_W-1:0]         dvd;
  logic [DW-1:0]           dvs;
  logic [DW-1:0]           rem;
  logic [$clog2(SQ_W)-1:0] cnt;
  logic                    busy;
  logic [DW:0]             trial;
  logic                    qbit;
  logic [DW:0]             diff;

  always_comb begin
    trial = {rem, dvd[SQ_W-1]};
    diff  = trial - {1'b0, dvs};
    qbit  = trial >= {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == $clog2(SQ_W)'(SQ_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      dvs <= divisor;
      rem <= '0;
    end else if (busy) begin
      dvd <= {dvd[SQ_W-2:0], qbit};
      rem <= qbit ? diff[DW-1:0] : trial[DW-1:0];
    end
  end

  assign quot   = dvd;
  assign rem_nz = rem != '0;
endmodule

FILE: rtl/rpab_sqrt.sv
// ----------------------------------------------------------------------------
// rpab_sqrt
// digit-recurrence integer square root, one root bit per cycle
// ----------------------------------------------------------------------------
module rpab_sqrt
  import rpab_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [SQ_W-1:0] value,
  output logic            done,
  output logic [CH_W-1:0] root
);
  logic [SQ_W-1:0]         v_r;
  logic [CH_W+1:0]         rem;
  logic [$clog2(CH_W)-1:0] cnt;
  logic                    busy;
  logic [CH_W+3:0]         rs;
  logic [CH_W+3:0]         trial;
  logic                    take;

  always_comb begin
    rs    = {rem, v_r[SQ_W-1:SQ_W-2]};
    trial = {2'b00, root, 2'b01};
    take  = rs >= trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == $clog2(CH_W)'(CH_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      v_r  <= value;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      v_r  <= {v_r[SQ_W-3:0], 2'b00};
      rem  <= take ? rs[CH_W+1:0] - trial[CH_W+1:0] : rs[CH_W+1:0];
      root <= {root[CH_W-2:0], take};
    end
  end
endmodule

FILE: rtl/rms_pixel_accumulation_buffer_unit.sv
// accumulate: per channel a serial square of the stored value, a square of the input, a divide and a root
// read: per channel a divide through the serial divider, skipped when the peak is zero
// peak measure: one store read per pixel of the active area
// one request in flight at a time; the result register lets the next one start
// after rst the store is cleared one entry per cycle, all MAX_WIDTH*MAX_HEIGHT entries,
// and no request is taken until then
// ----------------------------------------------------------------------------
// rms_pixel_accumulation_buffer_unit
// per-pixel rms accumulation store with peak measure and tonemapped read
// ----------------------------------------------------------------------------
module rms_pixel_accumulation_buffer_unit
  import rpab_pkg::*;
#(
  parameter int MAX_WIDTH     = 256,
  parameter int MAX_HEIGHT    = 256,
  parameter int FRACTION_BITS = 12,
  parameter int COUNT_BITS    = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,  // column, row, red_in, green_in, blue_in
  input  logic [1:0]  s_tuser,  // op
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata   // red_out, green_out, blue_out, peak_value, sample_count
);
  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int EW    = 3 * CH_W + COUNT_BITS;
  localparam int DVW   = (COUNT_BITS > CH_W) ? COUNT_BITS : CH_W;
  localparam logic [CH_W-1:0] ONE = CH_W'(1 << FRACTION_BITS);

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_RD   = 4'd2;
  localparam logic [3:0] S_RDW  = 4'd3;
  localparam logic [3:0] S_MO   = 4'd4;
  localparam logic [3:0] S_MC   = 4'd5;
  localparam logic [3:0] S_DIV  = 4'd6;
  localparam logic [3:0] S_SQ   = 4'd7;
  localparam logic [3:0] S_WR   = 4'd8;
  localparam logic [3:0] S_TONE = 4'd9;
  localparam logic [3:0] S_PK   = 4'd10;
  localparam logic [3:0] S_PKT  = 4'd11;
  localparam logic [3:0] S_FIN  = 4'd12;

  logic [3:0]       state;
  logic [REG_W-1:0] active_width;
  logic [REG_W-1:0] active_height;
  logic [CH_W-1:0]  peak;

  logic [EW-1:0]    mem [DEPTH];
  logic [EW-1:0]    rd_data;
  logic [AW-1:0]    raddr;
  logic [AW-1:0]    waddr;
  logic [EW-1:0]    wdata;
  logic             we;
  logic [AW-1:0]    clr_addr;

  logic [1:0]       op;
  logic [CH_W-1:0]  cin [3];
  logic [AW-1:0]    idx;
  logic [3*CH_W-1:0] ent;
  logic [CH_W-1:0]  newch [3];
  logic [7:0]       tone [3];
  logic [COUNT_BITS-1:0] n;
  logic [15:0]      res_count;
  logic [1:0]       ch;
  logic             run;
  logic [SQ_W-1:0]  o2;
  logic             ge;
  logic [SQ_W-1:0]  sq_in;

  logic [CRD_W-1:0] wl;
  logic [CRD_W-1:0] hl;
  logic [CRD_W-1:0] x;
  logic [CRD_W-1:0] y;
  logic             pend;
  logic [CH_W-1:0]  best;
  logic [CH_W-1:0]  best_next;

  logic [CRD_W-1:0] col_e;
  logic [CRD_W-1:0] row_e;
  logic             in_area;
  logic [CRD_W-1:0] aw_e;
  logic [CRD_W-1:0] ah_e;
  logic [31:0]      lin_in;
  logic [31:0]      lin_pk;
  logic [CH_W-1:0]  old_ch;
  logic [CH_W-1:0]  ent_ch [3];
  logic [COUNT_BITS+15:0] cnt_ext;
  logic [CH_W-1:0]  rd_ch [3];

  logic             mul_start;
  logic             mul_done;
  logic [CH_W-1:0]  mul_a;
  logic [SQ_W-1:0]  mul_prod;
  logic             div_start;
  logic             div_done;
  logic [SQ_W-1:0]  div_dvd;
  logic [DVW-1:0]   div_dvs;
  logic [SQ_W-1:0]  div_quot;
  logic             div_rem_nz;
  logic             sq_start;
  logic             sq_done;
  logic [CH_W-1:0]  sq_root;
  logic [CH_W+7:0]  v255;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_HEIGHT) ? {{(32 - REG_W){1'b0}}, active_height}
                                           : {{(32 - REG_W){1'b0}}, active_width};

  always_ff @(posedge clk) begin
    if (rst) begin
      active_width  <= REG_W'(256);
      active_height <= REG_W'(256);
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == REG_WIDTH) begin
        active_width <= pwdata[REG_W-1:0];
      end else begin
        active_height <= pwdata[REG_W-1:0];
      end
    end
  end

  always_comb begin
    col_e   = {{(CRD_W - 8){1'b0}}, s_tdata[7:0]};
    row_e   = {{(CRD_W - 8){1'b0}}, s_tdata[15:8]};
    in_area = (col_e < CRD_W'(MAX_WIDTH)) && (row_e < CRD_W'(MAX_HEIGHT));
    lin_in  = 32'(row_e) * 32'(MAX_WIDTH) + 32'(col_e);
    aw_e    = {{(CRD_W - REG_W){1'b0}}, active_width};
    ah_e    = {{(CRD_W - REG_W){1'b0}}, active_height};
    lin_pk  = 32'(y) * 32'(MAX_WIDTH) + 32'(x);
    for (int k = 0; k < 3; k++) begin
      ent_ch[k] = ent[k*CH_W +: CH_W];
      rd_ch[k]  = rd_data[k*CH_W +: CH_W];
    end
    old_ch    = ent_ch[ch];
    cnt_ext   = {16'd0, n};
    v255      = {old_ch, 8'd0} - {8'd0, old_ch};
    best_next = best;
    if (pend) begin
      for (int k = 0; k < 3; k++) begin
        if (rd_ch[k] > best_next) begin
          best_next = rd_ch[k];
        end
      end
    end
  end

  // store: one write port, one registered read port
  always_comb begin
    raddr = (state == S_PK) ? lin_pk[AW-1:0] : idx;
    we    = (state == S_CLR) || (state == S_WR);
    waddr = (state == S_CLR) ? clr_addr : idx;
    wdata = (state == S_CLR) ? {{COUNT_BITS{1'b0}}, ONE, ONE, ONE}
                             : {n, newch[2], newch[1], newch[0]};
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_data <= mem[raddr];
  end

  // arithmetic units, started once per channel in each of their wait states, while run is low
  always_comb begin
    mul_start = ((state == S_MO) || (state == S_MC)) && !run;
    mul_a     = (state == S_MO) ? old_ch : cin[ch];
    div_start = (state == S_DIV) || ((state == S_TONE) && (peak != '0));
    div_start = div_start && !run;
    div_dvd   = (state == S_TONE) ? SQ_W'(v255) : sq_in;
    div_dvs   = (state == S_TONE) ? DVW'(peak) : DVW'(n);
    sq_start  = (state == S_SQ) && !run;
  end

  rpab_mul u_mul (
    .clk  (clk),
    .rst  (rst),
    .start(mul_start),
    .a    (mul_a),
    .b    (mul_a),
    .done (mul_done),
    .prod (mul_prod)
  );

  rpab_div #(.DW(DVW)) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend(div_dvd),
    .divisor (div_dvs),
    .done    (div_done),
    .quot    (div_quot),
    .rem_nz  (div_rem_nz)
  );

  rpab_sqrt u_sqrt (
    .clk  (clk),
    .rst  (rst),
    .start(sq_start),
    .value(sq_in),
    .done (sq_done),
    .root (sq_root)
  );

  assign s_tready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLR;
      clr_addr <= '0;
      run      <= 1'b0;
      pend     <= 1'b0;
      m_tvalid <= 1'b0;
      peak     <= ONE;
    end else begin
      if (m_tvalid && m_tready && (state != S_FIN)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_CLR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == AW'(DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (s_tvalid) begin
            op  <= s_tuser;
            idx <= lin_in[AW-1:0];
            cin[0] <= s_tdata[31:16];
            cin[1] <= s_tdata[47:32];
            cin[2] <= s_tdata[63:48];
            for (int k = 0; k < 3; k++) begin
              tone[k] <= '0;
            end
            res_count <= '0;
            ch <= '0;
            wl <= (aw_e < CRD_W'(MAX_WIDTH)) ? aw_e : CRD_W'(MAX_WIDTH);
            hl <= (ah_e < CRD_W'(MAX_HEIGHT)) ? ah_e : CRD_W'(MAX_HEIGHT);
            x    <= '0;
            y    <= '0;
            best <= '0;
            pend <= 1'b0;
            if (s_tuser == OP_PEAK) begin
              if (active_width == '0 || active_height == '0) begin
                peak  <= '0;
                state <= S_FIN;
              end else begin
                state <= S_PK;
              end
            end else if ((s_tuser == OP_ACC || s_tuser == OP_READ) && in_area) begin
              state <= S_RD;
            end else begin
              state <= S_FIN;
            end
          end
        end
        S_RD: begin
          state <= S_RDW;
        end
        S_RDW: begin
          ent <= rd_data[3*CH_W-1:0];
          if (op == OP_ACC) begin
            n <= (rd_data[EW-1 -: COUNT_BITS] == '1) ? rd_data[EW-1 -: COUNT_BITS]
                                                      : rd_data[EW-1 -: COUNT_BITS] + 1'b1;
            state <= S_MO;
          end else begin
            n     <= rd_data[EW-1 -: COUNT_BITS];
            state <= S_TONE;
          end
        end
        S_MO: begin
          if (mul_done) begin
            o2    <= mul_prod;
            run   <= 1'b0;
            state <= S_MC;
          end else begin
            run <= 1'b1;
          end
        end
        S_MC: begin
          if (mul_done) begin
            ge    <= mul_prod >= o2;
            sq_in <= (mul_prod >= o2) ? mul_prod - o2 : o2 - mul_prod;
            run   <= 1'b0;
            state <= S_DIV;
          end else begin
            run <= 1'b1;
          end
        end
        S_DIV: begin
          if (div_done) begin
            sq_in <= ge ? o2 + div_quot : o2 - (div_quot + SQ_W'(div_rem_nz));
            run   <= 1'b0;
            state <= S_SQ;
          end else begin
            run <= 1'b1;
          end
        end
        S_SQ: begin
          if (sq_done) begin
            newch[ch] <= sq_root;
            run       <= 1'b0;
            if (ch == 2'd2) begin
              state <= S_WR;
            end else begin
              ch    <= ch + 1'b1;
              state <= S_MO;
            end
          end else begin
            run <= 1'b1;
          end
        end
        S_WR: begin
          res_count <= cnt_ext[15:0];
          state     <= S_FIN;
        end
        S_TONE: begin
          if (peak == '0) begin
            tone[ch] <= '0;
            if (ch == 2'd2) begin
              res_count <= cnt_ext[15:0];
              state     <= S_FIN;
            end else begin
              ch <= ch + 1'b1;
            end
          end else if (div_done) begin
            tone[ch] <= (div_quot > SQ_W'(255)) ? 8'd255 : div_quot[7:0];
            run      <= 1'b0;
            if (ch == 2'd2) begin
              res_count <= cnt_ext[15:0];
              state     <= S_FIN;
            end else begin
              ch <= ch + 1'b1;
            end
          end else begin
            run <= 1'b1;
          end
        end
        S_PK: begin
          best <= best_next;
          pend <= 1'b1;
          if (x == wl - 1'b1) begin
            x <= '0;
            y <= y + 1'b1;
            if (y == hl - 1'b1) begin
              state <= S_PKT;
            end
          end else begin
            x <= x + 1'b1;
          end
        end
        S_PKT: begin
          peak  <= best_next;
          pend  <= 1'b0;
          state <= S_FIN;
        end
        S_FIN: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {res_count, peak, tone[2], tone[1], tone[0]};
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end
endmodule

FILE: rtl/rpab_checker.sv
// ----------------------------------------------------------------------------
// rpab_checker
// port-level checks of the rms pixel accumulation buffer
// ----------------------------------------------------------------------------
module rpab_checker (
  input logic        clk,
  input logic        rst,
  input logic        pready,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [55:0] m_tdata
);
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata))
    else $error("result changed while stalled");

  a_one_request: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second request taken while busy");

  a_clear_pass: assert property (@(posedge clk)
    rst |=> !s_tready)
    else $error("request taken before store clear");

  a_pready: assert property (@(posedge clk) pready)
    else $error("pready low");
endmodule

bind rms_pixel_accumulation_buffer_unit rpab_checker u_rpab_checker (
  .clk     (clk),
  .rst     (rst),
  .pready  (pready),
  .s_tvalid(s_tvalid),
  .s_tready(s_tready),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata)
);
